// ----- src/two_colour_blob_centroid_defines.svh -----
// Assertion helpers for the RTL of the blob centroid block, included by tcbc_back.
`ifndef TWO_COLOUR_BLOB_CENTROID_DEFINES_SVH
`define TWO_COLOUR_BLOB_CENTROID_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define TCBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcbc: implication violated");

// Condition that must never be seen outside reset.
`define TCBC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tcbc: forbidden condition seen");

`endif

// ----- src/tcbc_pkg.sv -----
package tcbc_pkg;

  localparam int unsigned SumW   = 30;
  localparam int unsigned CntW   = 21;
  localparam int unsigned PixW   = 10;
  localparam int unsigned CoordW = 11;
  localparam int unsigned BoundW = 24;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [7:0] HueLimit = 8'd179;
  localparam logic [PixW-1:0] CoordLimit = '1;

  // register indexes
  localparam logic [CfgAddrW-1:0] CfgPinkLo   = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgPinkHi   = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgOrangeLo = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgOrangeHi = 3'd3;

  localparam logic [BoundW-1:0] PinkLoReset   = 24'h9D46A0;
  localparam logic [BoundW-1:0] PinkHiReset   = 24'hB3FFFF;
  localparam logic [BoundW-1:0] OrangeLoReset = 24'h055ADF;
  localparam logic [BoundW-1:0] OrangeHiReset = 24'h0FB9FF;

  typedef struct packed {
    logic [SumW-1:0] sum_col;
    logic [SumW-1:0] sum_row;
    logic [CntW-1:0] count;
  } blob_acc_t;

  typedef struct packed {
    blob_acc_t pink;
    blob_acc_t orange;
  } frame_rec_t;

  function automatic logic [7:0] clip_hue(logic [BoundW-1:0] bound);
    logic [7:0] h;
    h = bound[23:16];
    return (h > HueLimit) ? HueLimit : h;
  endfunction

  function automatic logic in_box(logic [BoundW-1:0] lo, logic [BoundW-1:0] hi,
                                  logic [7:0] h, logic [7:0] s, logic [7:0] v);
    return (h >= clip_hue(lo)) && (h <= clip_hue(hi)) &&
           (s >= lo[15:8]) && (s <= hi[15:8]) &&
           (v >= lo[7:0]) && (v <= hi[7:0]);
  endfunction

  // saturating accumulate of one pixel
  function automatic blob_acc_t acc_add(blob_acc_t a, logic [PixW-1:0] c,
                                        logic [PixW-1:0] r);
    logic [SumW:0] sc;
    logic [SumW:0] sr;
    logic [CntW:0] cc;
    blob_acc_t     res;
    sc = {1'b0, a.sum_col} + (SumW+1)'(c);
    sr = {1'b0, a.sum_row} + (SumW+1)'(r);
    cc = {1'b0, a.count} + (CntW+1)'(1);
    res.sum_col = sc[SumW] ? '1 : sc[SumW-1:0];
    res.sum_row = sr[SumW] ? '1 : sr[SumW-1:0];
    res.count   = cc[CntW] ? '1 : cc[CntW-1:0];
    return res;
  endfunction

endpackage

// ----- src/two_colour_blob_centroid.sv -----
// Two-colour blob centroid tracker.
// Pixel channel: queue style. A pixel (HSV, col, row, end_of_frame) is taken
// on a clock edge with push_i high and full_o low; one pixel per cycle.
// Each pixel is classified against the pink and orange HSV boxes and summed
// in the same cycle. The last pixel of a frame hands the frame totals to a
// two-entry frame queue and clears the sums, so the next frame streams on.
// full_o rises only when two finished frames still wait for the divider.
// Result channel: one result per frame, valid while empty_o is low, taken on
// a clock edge with pop_i high. The divider produces the four centroid
// coordinates at one quotient bit a cycle; when only one colour or none was
// seen, the divider is skipped and the result goes straight to the output.
// A result that is not popped holds the output register and the divider
// waits behind it; the frame queue absorbs up to two more frames.
// Reset restores the default color boxes, clears the sums and sets the stored
// coordinates to -1. Configuration writes (cfg_we_i, cfg_addr_i) act at once.
module two_colour_blob_centroid #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tcbc_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [tcbc_pkg::BoundW-1:0]         cfg_wdata_i,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [7:0]                          hue_i,
  input  logic [7:0]                          saturation_i,
  input  logic [7:0]                          brightness_i,
  input  logic [tcbc_pkg::PixW-1:0]           col_i,
  input  logic [tcbc_pkg::PixW-1:0]           row_i,
  input  logic                                end_of_frame_i,
  input  logic                                pop_i,
  output logic                                empty_o,
  output logic                                found_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  front_col_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  front_row_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  back_col_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  back_row_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  mid_col_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  mid_row_o
);
  import tcbc_pkg::*;

  frame_rec_t push_rec, pop_rec;
  logic       rec_push, rec_full, rec_valid, rec_pop;

  tcbc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push_i),
    .full_o        (full_o),
    .hue_i         (hue_i),
    .saturation_i  (saturation_i),
    .brightness_i  (brightness_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .end_of_frame_i(end_of_frame_i),
    .rec_push_o    (rec_push),
    .rec_o         (push_rec),
    .rec_full_i    (rec_full)
  );

  tcbc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .data_i (push_rec),
    .full_o (rec_full),
    .pop_i  (rec_pop),
    .valid_o(rec_valid),
    .data_o (pop_rec)
  );

  tcbc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(rec_valid),
    .rec_i      (pop_rec),
    .rec_pop_o  (rec_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .found_o    (found_o),
    .front_col_o(front_col_o),
    .front_row_o(front_row_o),
    .back_col_o (back_col_o),
    .back_row_o (back_row_o),
    .mid_col_o  (mid_col_o),
    .mid_row_o  (mid_row_o)
  );

endmodule

// ----- src/tcbc_front.sv -----
module tcbc_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcbc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [tcbc_pkg::BoundW-1:0]   cfg_wdata_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [7:0]                    hue_i,
  input  logic [7:0]                    saturation_i,
  input  logic [7:0]                    brightness_i,
  input  logic [tcbc_pkg::PixW-1:0]     col_i,
  input  logic [tcbc_pkg::PixW-1:0]     row_i,
  input  logic                          end_of_frame_i,
  output logic                          rec_push_o,
  output tcbc_pkg::frame_rec_t          rec_o,
  input  logic                          rec_full_i
);
  import tcbc_pkg::*;

  logic [BoundW-1:0] pink_lo_q, pink_hi_q, orange_lo_q, orange_hi_q;
  blob_acc_t         pink_q, orange_q, pink_d, orange_d;
  logic              accept, in_frame, pink_hit, orange_hit;

  assign full_o = rec_full_i;
  assign accept = push_i && !rec_full_i;

  assign in_frame = (32'(col_i) < 32'(MAX_WIDTH)) && (32'(row_i) < 32'(MAX_HEIGHT));
  assign pink_hit = in_frame &&
                    in_box(pink_lo_q, pink_hi_q, hue_i, saturation_i, brightness_i);
  assign orange_hit = in_frame &&
                      in_box(orange_lo_q, orange_hi_q, hue_i, saturation_i, brightness_i);

  assign pink_d   = pink_hit ? acc_add(pink_q, col_i, row_i) : pink_q;
  assign orange_d = orange_hit ? acc_add(orange_q, col_i, row_i) : orange_q;

  // last pixel is counted before the frame totals are handed on
  assign rec_push_o    = accept && end_of_frame_i;
  assign rec_o.pink    = pink_d;
  assign rec_o.orange  = orange_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pink_lo_q   <= PinkLoReset;
      pink_hi_q   <= PinkHiReset;
      orange_lo_q <= OrangeLoReset;
      orange_hi_q <= OrangeHiReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgPinkLo:   pink_lo_q   <= cfg_wdata_i;
        CfgPinkHi:   pink_hi_q   <= cfg_wdata_i;
        CfgOrangeLo: orange_lo_q <= cfg_wdata_i;
        CfgOrangeHi: orange_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pink_q   <= '0;
      orange_q <= '0;
    end else if (accept) begin
      if (end_of_frame_i) begin
        pink_q   <= '0;
        orange_q <= '0;
      end else begin
        pink_q   <= pink_d;
        orange_q <= orange_d;
      end
    end
  end

endmodule

// ----- src/tcbc_fifo.sv -----
module tcbc_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tcbc_pkg::frame_rec_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output tcbc_pkg::frame_rec_t data_o
);
  import tcbc_pkg::*;

  frame_rec_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- src/tcbc_back.sv -----
`include "two_colour_blob_centroid_defines.svh"

module tcbc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rec_valid_i,
  input  tcbc_pkg::frame_rec_t                rec_i,
  output logic                                rec_pop_o,
  input  logic                                pop_i,
  output logic                                empty_o,
  output logic                                found_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  front_col_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  front_row_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  back_col_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  back_row_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  mid_col_o,
  output logic signed [tcbc_pkg::CoordW-1:0]  mid_row_o
);
  import tcbc_pkg::*;

  typedef enum logic [2:0] {SIdle, SLoad, SDiv, SMid, SOut} state_e;

  localparam int unsigned StepW = $clog2(SumW);
  localparam logic [StepW-1:0] LastStep = StepW'(SumW - 1);

  state_e                    state_q;
  frame_rec_t                rec_q;
  logic [1:0]                sel_q;
  logic [StepW-1:0]          step_q;
  logic [CntW-1:0]           rem_q;
  logic [SumW-1:0]           dvd_q;
  logic [PixW-1:0]           quot_q [4];
  logic signed [CoordW-1:0]  coord_q [6];
  logic                      found_q, out_valid_q;

  logic [CntW-1:0] div_cnt;
  logic [SumW-1:0] div_sum;
  logic [CntW:0]   rem_sh, rem_sub;
  logic            q_bit;
  logic [SumW-1:0] quo;
  logic [PixW-1:0] quo_clip;
  logic [PixW:0]   mid_c_sum, mid_r_sum;
  logic            both_seen;
  logic            out_load;

  assign div_cnt = sel_q[1] ? rec_q.orange.count : rec_q.pink.count;
  always_comb begin
    case (sel_q)
      2'd0:    div_sum = rec_q.pink.sum_col;
      2'd1:    div_sum = rec_q.pink.sum_row;
      2'd2:    div_sum = rec_q.orange.sum_col;
      default: div_sum = rec_q.orange.sum_row;
    endcase
  end

  // one restoring-division step per cycle; quotient shifts into dvd_q
  assign rem_sh   = {rem_q, dvd_q[SumW-1]};
  assign rem_sub  = rem_sh - {1'b0, div_cnt};
  assign q_bit    = (rem_sh >= {1'b0, div_cnt});
  assign quo      = {dvd_q[SumW-2:0], q_bit};
  assign quo_clip = (|quo[SumW-1:PixW]) ? CoordLimit : quo[PixW-1:0];

  assign mid_c_sum = {1'b0, quot_q[0]} + {1'b0, quot_q[2]};
  assign mid_r_sum = {1'b0, quot_q[1]} + {1'b0, quot_q[3]};

  assign both_seen = (rec_i.pink.count != '0) && (rec_i.orange.count != '0);
  assign rec_pop_o = (state_q == SIdle) && rec_valid_i;

  assign empty_o     = !out_valid_q;
  assign out_load    = (state_q == SOut) && (!out_valid_q || pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      sel_q       <= 2'd0;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      found_o     <= 1'b0;
      for (int i = 0; i < 6; i++) coord_q[i] <= '1;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (rec_valid_i) begin
            rec_q   <= rec_i;
            sel_q   <= 2'd0;
            found_q <= both_seen;
            state_q <= both_seen ? SLoad : SOut;
          end
        end
        SLoad: begin
          rem_q   <= '0;
          dvd_q   <= div_sum;
          step_q  <= '0;
          state_q <= SDiv;
        end
        SDiv: begin
          rem_q  <= q_bit ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
          dvd_q  <= quo;
          step_q <= step_q + StepW'(1);
          if (step_q == LastStep) begin
            quot_q[sel_q] <= quo_clip;
            sel_q         <= sel_q + 2'd1;
            state_q       <= (sel_q == 2'd3) ? SMid : SLoad;
          end
        end
        SMid: begin
          for (int i = 0; i < 4; i++) coord_q[i] <= CoordW'(quot_q[i]);
          coord_q[4] <= CoordW'(mid_c_sum[PixW:1]);
          coord_q[5] <= CoordW'(mid_r_sum[PixW:1]);
          state_q    <= SOut;
        end
        SOut: begin
          if (out_load) begin
            found_o     <= found_q;
            front_col_o <= coord_q[0];
            front_row_o <= coord_q[1];
            back_col_o  <= coord_q[2];
            back_row_o  <= coord_q[3];
            mid_col_o   <= coord_q[4];
            mid_row_o   <= coord_q[5];
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `TCBC_ASSERT_IMP(a_div_rem_below_count, state_q == SDiv, rem_q < div_cnt)
  `TCBC_ASSERT_NEVER(a_divide_by_zero, (state_q == SDiv) && (div_cnt == '0))
  `TCBC_ASSERT_IMP(a_found_has_coords, !empty_o && found_o,
                   (front_col_o != '1) && (back_row_o != '1) && (mid_row_o != '1))
  `TCBC_ASSERT_IMP(a_mid_between, !empty_o && found_o,
                   (mid_col_o >= front_col_o || mid_col_o >= back_col_o) &&
                   (mid_col_o <= front_col_o || mid_col_o <= back_col_o))

endmodule
